// ===== design/hmnm_pkg.sv =====
// Package for the height map to normal map block.
// Holds the sequencer state type, register indexes, reset values, widths, input kinds and component order.
// No dependencies.
`default_nettype none

package hmnm_pkg;

    // Row store depth default
    localparam int unsigned MAX_WIDTH_DEF = 1024;

    // Configuration port widths
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_TERM    = 2'd2;

    // Register widths and reset values
    localparam int unsigned IW_W = 11;
    localparam int unsigned IH_W = 13;
    localparam int unsigned FT_W = 16;
    localparam logic [IW_W-1:0] IMAGE_WIDTH_RST  = 11'd256;
    localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = 13'd256;
    localparam logic [FT_W-1:0] FLAT_TERM_RST    = 16'd6528;

    // Width used for row-size arithmetic (covers the width register and the depth)
    localparam int unsigned SZ_W = 13;

    // Input kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Normal component order
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // Arithmetic widths
    localparam int unsigned SUM_W  = 34;  // sum of squares
    localparam int unsigned ROOT_W = 17;  // integer square root
    localparam int unsigned SQRT_STEPS = SUM_W / 2;
    localparam int unsigned NUM_W  = 28;  // signed dividend
    localparam int unsigned REM_W  = 27;
    localparam int unsigned QUO_W  = 9;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LATCH,
        S_SQUARE,
        S_SUM,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== design/height_map_to_normal_map_top.sv =====
// Height map to normal map: top level with row stores, sequencer and arithmetic.
// Depends on hmnm_pkg.
// Per normal: read the row stores, latch the differences, square, sum, 17 root steps, then
// a divider load and divide steps for each component, and the output load, held on a stall.
// Row-0 samples and dropped words do not start the sequencer; a word that yields a normal
// blocks input until its normal is loaded, a span set by the bit-serial root and shared divider.
// Reset: synchronous, active low; counters, flush flag and registers return to
// their defaults; the row stores are not cleared.
`default_nettype none

module height_map_to_normal_map_top #(
    parameter int unsigned MAX_WIDTH = hmnm_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [hmnm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hmnm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [7:0]                      i_s_tdata,   // [7:0] height_sample
    input  wire logic                            i_s_tuser,   // [0] op
    // output stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [23:0]                          o_m_tdata,   // [7:0] red, [15:8] green,
                                                              // [23:16] blue
    output logic                                 o_m_tlast    // last_pixel
);
    import hmnm_pkg::*;

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Configuration registers
    logic [IW_W-1:0] r_image_width;
    logic [IH_W-1:0] r_image_height;
    logic [FT_W-1:0] r_flat_term;

    // Position state
    logic [AW-1:0]   r_col;
    logic [IH_W-1:0] r_row;
    logic            r_flush_active;

    // Row stores
    logic [7:0] older_row [MAX_WIDTH];
    logic [7:0] newer_row [MAX_WIDTH];
    logic [7:0] r_new_c, r_new_r, r_old_c, r_old_l;

    // Per-pixel work registers
    t_state r_state, n_state;
    logic [AW-1:0] r_x, r_xr, r_xl;
    logic          r_has_left, r_has_right, r_first, r_is_flush, r_last;
    logic [7:0]    r_sample, r_below;
    logic signed [8:0] r_dx, r_dy;
    logic [15:0]       r_sqx, r_sqy;
    logic [31:0]       r_sqz;
    logic [SUM_W-1:0]  r_v, r_res, r_bit;
    logic [4:0]        r_sqrt_cnt;
    logic [ROOT_W-1:0] r_root;
    logic [1:0]        r_comp;
    logic [REM_W-1:0]  r_rem, r_dv;
    logic [QUO_W-1:0]  r_q;
    logic [3:0]        r_step;
    logic [7:0]        r_red, r_green, r_blue;

    // Output register
    logic        r_m_valid;
    logic [23:0] r_m_data;
    logic        r_m_last;

    // Effective sizes
    logic [SZ_W-1:0] w_ext, w_eff, h_eff;
    logic [AW-1:0]   w_m1, x_eff;
    logic [IH_W-1:0] h_m1, y_eff;
    logic [FT_W-1:0] ft_eff;

    always_comb begin
        w_ext = SZ_W'(r_image_width);
        if (w_ext == '0) begin
            w_eff = SZ_W'(1);
        end else if (w_ext > SZ_W'(MAX_WIDTH)) begin
            w_eff = SZ_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        w_m1   = AW'(w_eff - SZ_W'(1));
        h_eff  = (r_image_height == '0) ? SZ_W'(1) : SZ_W'(r_image_height);
        h_m1   = IH_W'(h_eff - SZ_W'(1));
        x_eff  = (r_col > w_m1) ? w_m1 : r_col;
        y_eff  = (r_row > h_m1) ? h_m1 : r_row;
        ft_eff = (r_flat_term == '0) ? FT_W'(1) : r_flat_term;
    end

    // Accept decode
    logic acc, is_flush, row_end, img_end, emit, fill;
    assign o_s_tready  = (r_state == S_IDLE);
    assign acc         = i_s_tvalid && o_s_tready;
    assign is_flush    = (i_s_tuser == OP_FLUSH);
    assign row_end     = (x_eff == w_m1);
    assign img_end     = (y_eff == h_m1);
    assign emit        = acc && (is_flush ? r_flush_active
                                          : (!r_flush_active && (y_eff != '0)));
    assign fill        = acc && !is_flush && !r_flush_active && (y_eff == '0);
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_flat_term    <= FLAT_TERM_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IW_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[IH_W-1:0];
                CFG_FLAT_TERM:    r_flat_term    <= i_cfg_data[FT_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance column, row and flush flag on each accepted word that is not dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col          <= '0;
            r_row          <= '0;
            r_flush_active <= 1'b0;
        end else if (acc) begin
            if (is_flush) begin
                if (r_flush_active) begin
                    if (row_end) begin
                        r_col          <= '0;
                        r_row          <= '0;
                        r_flush_active <= 1'b0;
                    end else begin
                        r_col <= x_eff + AW'(1);
                    end
                end
            end else if (!r_flush_active) begin
                if (row_end) begin
                    r_col <= '0;
                    if (img_end) begin
                        r_row          <= '0;
                        r_flush_active <= 1'b1;
                    end else begin
                        r_row <= y_eff + IH_W'(1);
                    end
                end else begin
                    r_col <= x_eff + AW'(1);
                    r_row <= y_eff;
                end
            end
        end
    end

    // Row store ports: two reads each, one write each
    logic          new_we, old_we;
    logic [AW-1:0] new_wa;
    logic [7:0]    new_wd;
    always_comb begin
        new_we = 1'b0;
        new_wa = r_x;
        new_wd = r_sample;
        if (fill) begin
            new_we = 1'b1;
            new_wa = x_eff;
            new_wd = i_s_tdata;
        end else if (r_state == S_LATCH && !r_is_flush) begin
            new_we = 1'b1;
        end
        old_we = (r_state == S_LATCH);
    end

    always_ff @(posedge i_clk) begin
        if (new_we) begin
            newer_row[new_wa] <= new_wd;
        end
        if (r_state == S_READ) begin
            r_new_c <= newer_row[r_x];
            r_new_r <= newer_row[r_xr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (old_we) begin
            older_row[r_x] <= r_new_c;
        end
        if (r_state == S_READ) begin
            r_old_c <= older_row[r_x];
            r_old_l <= older_row[r_xl];
        end
    end

    // Square root step
    logic [SUM_W:0] sq_trial;
    logic           sq_take;
    assign sq_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign sq_take  = ({1'b0, r_v} >= sq_trial);

    // Divide step and dividend for the current component
    logic signed [16:0]      comp_v;
    logic [ROOT_W-1:0]       root_cur;
    logic signed [NUM_W-1:0] num;
    logic                    dv_take;
    logic [QUO_W-1:0]        q_next;
    logic [7:0]              q_sat;
    always_comb begin
        unique case (r_comp)
            COMP_X:  comp_v = {r_dx, 8'd0};
            COMP_Y:  comp_v = {r_dy, 8'd0};
            default: comp_v = {1'b0, ft_eff};
        endcase
        // Take the fresh root for the first component, the held one after
        root_cur = (r_comp == COMP_X) ? ROOT_W'(r_res) : r_root;
        num = (NUM_W'(root_cur) <<< 8) + (NUM_W'(comp_v) <<< 8) - NUM_W'(comp_v);
        dv_take = (r_rem >= r_dv);
        q_next  = {r_q[QUO_W-2:0], dv_take};
        q_sat   = q_next[QUO_W-1] ? 8'd255 : q_next[7:0];
    end

    // Sequencer next state
    logic out_free;
    assign out_free = !r_m_valid || i_m_tready;
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (emit) n_state = S_READ;
            S_READ:     n_state = S_LATCH;
            S_LATCH:    n_state = S_SQUARE;
            S_SQUARE:   n_state = S_SUM;
            S_SUM:      n_state = S_SQRT;
            S_SQRT:     if (r_sqrt_cnt == 5'(SQRT_STEPS - 1)) n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (r_step == 4'(QUO_W - 1)) begin
                    n_state = (r_comp == COMP_Z) ? S_OUT : S_DIV_INIT;
                end
            end
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: latch, difference, square, root, divide
    logic [7:0] left_v, right_v, above_v, below_v;
    always_comb begin
        left_v  = r_has_left  ? r_old_l : r_new_c;
        right_v = r_has_right ? r_new_r : r_new_c;
        above_v = r_first     ? r_new_c : r_old_c;
        below_v = r_is_flush  ? r_new_c : r_below;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (emit) begin
                    r_x         <= x_eff;
                    r_xr        <= row_end ? x_eff : x_eff + AW'(1);
                    r_xl        <= (x_eff == '0) ? x_eff : x_eff - AW'(1);
                    r_has_left  <= (x_eff != '0);
                    r_has_right <= !row_end;
                    r_is_flush  <= is_flush;
                    r_first     <= is_flush ? (h_eff == SZ_W'(1)) : (y_eff == IH_W'(1));
                    r_last      <= is_flush && row_end;
                    r_sample    <= i_s_tdata;
                    r_below     <= i_s_tdata;
                end
            end
            S_LATCH: begin
                r_dx <= $signed({1'b0, left_v})  - $signed({1'b0, right_v});
                r_dy <= $signed({1'b0, above_v}) - $signed({1'b0, below_v});
            end
            S_SQUARE: begin
                r_sqx <= 16'(r_dx * r_dx);
                r_sqy <= 16'(r_dy * r_dy);
                r_sqz <= ft_eff * ft_eff;
            end
            S_SUM: begin
                r_v        <= (SUM_W'(r_sqx) << 16) + (SUM_W'(r_sqy) << 16) + SUM_W'(r_sqz);
                r_res      <= '0;
                r_bit      <= SUM_W'(1) << (SUM_W - 2);
                r_sqrt_cnt <= '0;
            end
            S_SQRT: begin
                if (sq_take) begin
                    r_v   <= r_v - SUM_W'(sq_trial);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit      <= r_bit >> 2;
                r_sqrt_cnt <= r_sqrt_cnt + 5'd1;
                r_comp     <= COMP_X;
            end
            S_DIV_INIT: begin
                if (r_comp == COMP_X) begin
                    r_root <= ROOT_W'(r_res);
                end
                r_rem  <= (num < 0) ? '0 : REM_W'(num);
                r_dv   <= REM_W'(root_cur) << 9;
                r_q    <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                if (dv_take) begin
                    r_rem <= r_rem - r_dv;
                end
                r_dv   <= r_dv >> 1;
                r_q    <= q_next;
                r_step <= r_step + 4'd1;
                if (r_step == 4'(QUO_W - 1)) begin
                    unique case (r_comp)
                        COMP_X:  r_red   <= q_sat;
                        COMP_Y:  r_green <= q_sat;
                        default: r_blue  <= q_sat;
                    endcase
                    r_comp <= r_comp + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // Output register: load a finished normal, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_m_data <= {r_blue, r_green, r_red};
            r_m_last <= r_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

    // Checks
    a_flush_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush_active |-> (r_row == '0))
        else $error("row counter not cleared while flushing");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_root != '0))
        else $error("zero root reached the divider");

    a_idle_flush_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_flush && !r_flush_active) |=> (r_state == S_IDLE))
        else $error("flush word started work while no image was complete");

    a_sqrt_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_sqrt_cnt == 5'(SQRT_STEPS - 1)) |=> (r_state == S_DIV_INIT))
        else $error("root loop did not hand over to the divider");

endmodule

`default_nettype wire

// ===== test/tb_height_map_to_normal_map_top.sv =====
// Testbench for height_map_to_normal_map_top: streams height images in raster
// order, predicts every normal word and compares it on the output stream.
// Depends on hmnm_pkg and the top-level RTL.
`default_nettype none

module tb_height_map_to_normal_map_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hmnm_pkg::*;

    localparam int ROW_DEPTH  = 1024;
    localparam int DRAIN_WAIT = 80;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_WORDS = 950;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } normal_t;

    // Tracks the block's row stores and counters and holds pending normals
    class normal_scoreboard;
        logic [7:0] upper_line [ROW_DEPTH];
        logic [7:0] lower_line [ROW_DEPTH];
        int unsigned col, row;
        bit flushing;
        logic [IW_W-1:0] width_reg;
        logic [IH_W-1:0] height_reg;
        logic [FT_W-1:0] flat_reg;
        normal_t pending_q[$];
        int errors;
        int useful_words;

        function new();
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            col = 0; row = 0; flushing = 0;
            width_reg = IMAGE_WIDTH_RST;
            height_reg = IMAGE_HEIGHT_RST;
            flat_reg = FLAT_TERM_RST;
            errors = 0; useful_words = 0;
        endfunction

        function int unsigned used_width();
            if (width_reg == 0) return 1;
            if (width_reg > ROW_DEPTH) return ROW_DEPTH;
            return width_reg;
        endfunction

        function int unsigned used_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg = data[IW_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg = data[IH_W-1:0];
                CFG_FLAT_TERM:    flat_reg = data[FT_W-1:0];
                default: ;
            endcase
        endfunction

        // Bitwise integer square root
        function longint unsigned int_root(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Map one component from -r..r to 0..255, ties rounding up
        function logic [7:0] to_byte(longint v, longint r);
            longint num, q;
            num = 255 * (r + v) + r;
            if (num < 0) return 8'd0;
            q = num / (2 * r);
            if (q > 255) q = 255;
            return q[7:0];
        endfunction

        function normal_t shade(int unsigned x, int unsigned w, bit top_row, int below);
            int center, above, left, right;
            longint vx, vy, vz, r;
            longint unsigned sum;
            normal_t n;
            center = lower_line[x];
            above = top_row ? center : upper_line[x];
            left = (x > 0) ? upper_line[x-1] : center;
            right = (x + 1 < w) ? lower_line[x+1] : center;
            vx = longint'(left - right) * 256;
            vy = longint'(above - below) * 256;
            vz = (flat_reg == 0) ? 1 : flat_reg;
            sum = vx * vx + vy * vy + vz * vz;
            r = int_root(sum);
            if (r == 0) r = 1;
            upper_line[x] = center[7:0];
            n.red = to_byte(vx, r);
            n.green = to_byte(vy, r);
            n.blue = to_byte(vz, r);
            n.last = 1'b0;
            return n;
        endfunction

        function void note_input(logic op, logic [7:0] h);
            int unsigned w, ht, x, y;
            normal_t n;
            w = used_width();
            ht = used_height();
            x = (col >= w) ? w - 1 : col;
            y = (row >= ht) ? ht - 1 : row;
            if (op == OP_FLUSH) begin
                if (!flushing) return;
                useful_words++;
                n = shade(x, w, ht == 1, lower_line[x]);
                if (x + 1 >= w) begin
                    n.last = 1'b1;
                    flushing = 0; col = 0; row = 0;
                end else begin
                    col = x + 1;
                end
                pending_q.push_back(n);
                return;
            end
            if (flushing) return;
            useful_words++;
            if (y != 0) pending_q.push_back(shade(x, w, y == 1, h));
            lower_line[x] = h;
            if (x + 1 >= w) begin
                col = 0;
                if (y + 1 >= ht) begin
                    row = 0;
                    flushing = 1;
                end else begin
                    row = y + 1;
                end
            end else begin
                col = x + 1;
                row = y;
            end
        endfunction

        function void check(normal_t got);
            normal_t exp_n;
            if (pending_q.size() == 0) begin
                $error("unexpected normal word %h", got);
                errors++;
                return;
            end
            exp_n = pending_q.pop_front();
            if (got.red !== exp_n.red) begin
                $error("red: expected %0d, got %0d", exp_n.red, got.red);
                errors++;
            end
            if (got.green !== exp_n.green) begin
                $error("green: expected %0d, got %0d", exp_n.green, got.green);
                errors++;
            end
            if (got.blue !== exp_n.blue) begin
                $error("blue: expected %0d, got %0d", exp_n.blue, got.blue);
                errors++;
            end
            if (got.last !== exp_n.last) begin
                $error("last_pixel: expected %0d, got %0d", exp_n.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic [7:0] s_data = '0;
    logic s_user = OP_SAMPLE;
    logic m_ready = 1'b0;
    wire logic o_cfg_ready, o_s_tready, o_m_tvalid, o_m_tlast;
    wire logic [23:0] o_m_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    normal_scoreboard sb = new();

    height_map_to_normal_map_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Randomly stall the output stream
    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted normal word
    always @(posedge i_clk) begin
        normal_t got;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            got = {o_m_tdata[7:0], o_m_tdata[15:8], o_m_tdata[23:16], o_m_tlast};
            sb.check(got);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready) || (cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_word(logic op, logic [7:0] h);
        s_user <= op;
        s_data <= h;
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(op, h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Present one register write; the caller drops valid after the last one
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Hold the sender until every pending normal has come out
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic configure(int w, int h, int flat);
        drain();
        cfg_write(CFG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
        cfg_write(CFG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
        cfg_write(CFG_FLAT_TERM, flat[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_height(int kind, int x, int y);
        case (kind)
            0: return 8'($urandom);
            1: return ((x + y) % 2) ? 8'd255 : 8'd0;
            2: return ($urandom_range(1)) ? 8'd255 : 8'd0;
            default: return 8'(x * 16 + y * 3);
        endcase
    endfunction

    // Stream one whole image plus its flush, with optional noise words
    task automatic run_image(int kind, bit noisy);
        int unsigned w, h;
        w = sb.used_width();
        h = sb.used_height();
        if (noisy && $urandom_range(3) == 0) send_word(OP_FLUSH, 8'($urandom));
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_word(OP_SAMPLE, pick_height(kind, x, y));
        for (int x = 0; x < w; x++) begin
            if (noisy && $urandom_range(9) == 0) send_word(OP_SAMPLE, 8'($urandom));
            send_word(OP_FLUSH, 8'($urandom));
        end
    endtask

    task automatic set_phase(int p);
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
        endcase
    endtask

    initial begin
        int phase;
        phase = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single pixel, flush when idle, sample during flush
        configure(1, 1, 1);
        send_word(OP_FLUSH, 8'hFF);
        send_word(OP_SAMPLE, 8'd255);
        send_word(OP_SAMPLE, 8'd0);
        send_word(OP_FLUSH, 8'h00);
        // Directed: steepest slopes with smallest and largest z term
        configure(2, 2, 1);
        run_image(1, 1'b0);
        configure(3, 2, 65535);
        run_image(2, 1'b1);
        // Zero register values behave as one
        configure(0, 0, 0);
        run_image(0, 1'b1);
        set_phase(2);
        configure(4, 1, 256);
        run_image(1, 1'b0);

        // Wider and taller images, with no idling to keep the run short
        set_phase(0);
        configure(64, 2, 6528);
        run_image(0, 1'b0);
        configure(1, 100, 300);
        run_image(0, 1'b0);

        // Random images with random content, reconfigured between them
        while (sb.useful_words < RANDOM_WORDS) begin
            int w, h, f;
            set_phase(phase);
            phase++;
            w = ($urandom_range(7) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
            h = $urandom_range(6, 1);
            case ($urandom_range(5))
                0: f = 1;
                1: f = 65535;
                2: f = $urandom_range(1000, 1);
                default: f = $urandom_range(65535);
            endcase
            configure(w, h, f);
            repeat ($urandom_range(3, 1)) run_image($urandom_range(3), 1'b1);
        end

        // Wait for the last normals
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
